>>> hdl/trpe_pkg.sv
// Shared constants, codes and types of the triangle region plane encoder.
package trpe_pkg;

    localparam int ROW_MAX     = 1024;
    localparam int OFFSET_BITS = 32;

    localparam int COL_W      = $clog2(ROW_MAX);
    localparam int LEN_W      = $clog2(ROW_MAX + 1);
    localparam int ROW_ADDR_W = COL_W + 1;
    localparam int PIX_W      = 8;
    localparam int RLEN_W     = 7;
    localparam int D_W        = 8;
    localparam int SUM_W      = LEN_W + D_W;
    localparam int OUT_OFF_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [RLEN_W-1:0]     REGION_LEN_MAX   = 7'd127;
    localparam logic [PIX_W-1:0]      COLOR_MASK_FIX   = 8'hfe;
    localparam logic [PIX_W-1:0]      ODD_BIT          = 8'h01;
    localparam logic [PIX_W-1:0]      COLOR_MASK_RESET = 8'hfe;
    localparam logic [CFG_DATA_W-1:0] ROW_LEN_RESET    = 11'd1024;

    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_FINAL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd1;

    typedef struct packed {
        logic              active;
        logic [RLEN_W-1:0] len;
        logic [PIX_W-1:0]  color;
    } trpe_info_t;

    localparam int INFO_W = $bits(trpe_info_t);

    typedef struct packed {
        logic                   valid;
        logic                   flush;
        logic [OFFSET_BITS-1:0] offset;
        logic [PIX_W-1:0]       value;
    } trpe_emit_t;

endpackage

>>> hdl/trpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module trpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

>>> hdl/trpe_obuf.sv
// Output stage: holds the newest byte write back so the final one can carry last.
module trpe_obuf (
    input  logic                            clk,
    input  logic                            rst_n,
    input  trpe_pkg::trpe_emit_t            emit,
    output logic                            emit_ready,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [trpe_pkg::OUT_OFF_W-1:0]  byte_offset,
    output logic [trpe_pkg::PIX_W-1:0]      byte_value,
    output logic                            last
);
    import trpe_pkg::*;

    logic                   pv_reg, pv_next;
    logic [OFFSET_BITS-1:0] po_reg, po_next;
    logic [PIX_W-1:0]       pval_reg, pval_next;
    logic                   ov_reg, ov_next;
    logic [OUT_OFF_W-1:0]   oo_reg, oo_next;
    logic [PIX_W-1:0]       oval_reg, oval_next;
    logic                   olast_reg, olast_next;
    logic                   free;
    logic [47:0]            po_wide;

    assign free       = !ov_reg || !out_stall;
    assign emit_ready = !pv_reg || free;
    assign po_wide    = 48'(po_reg);

    always_comb
    begin
        pv_next    = pv_reg;
        po_next    = po_reg;
        pval_next  = pval_reg;
        ov_next    = ov_reg;
        oo_next    = oo_reg;
        oval_next  = oval_reg;
        olast_next = olast_reg;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        if (emit.valid && emit_ready)
        begin
            if (pv_reg)
            begin
                ov_next    = 1'b1;
                oo_next    = po_wide[OUT_OFF_W-1:0];
                oval_next  = pval_reg;
                olast_next = 1'b0;
            end
            pv_next   = 1'b1;
            po_next   = emit.offset;
            pval_next = emit.value;
        end
        else if (emit.flush && emit_ready && pv_reg)
        begin
            ov_next    = 1'b1;
            oo_next    = po_wide[OUT_OFF_W-1:0];
            oval_next  = pval_reg;
            olast_next = 1'b1;
            pv_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= pv_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        po_reg    <= po_next;
        pval_reg  <= pval_next;
        oo_reg    <= oo_next;
        oval_reg  <= oval_next;
        olast_reg <= olast_next;
    end

    assign out_valid   = ov_reg;
    assign byte_offset = oo_reg;
    assign byte_value  = oval_reg;
    assign last        = olast_reg;

    a_flush_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.flush && !emit.valid && emit_ready && pv_reg) |=> (out_valid && last))
        else $error("flushed byte not marked last");

    a_push_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.valid && emit_ready && pv_reg) |=> (out_valid && !last))
        else $error("pushed byte wrongly marked last");

endmodule

>>> hdl/trpe_ctrl.sv
// Sequencer: visits columns, scans regions and edges, and issues byte writes.
module trpe_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       operation,
    input  logic [trpe_pkg::PIX_W-1:0]       pixel_value,
    input  logic                             cfg_valid,
    input  logic [trpe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [trpe_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             row_we,
    output logic [trpe_pkg::ROW_ADDR_W-1:0]  row_waddr,
    output logic [trpe_pkg::PIX_W-1:0]       row_wdata,
    output logic [trpe_pkg::ROW_ADDR_W-1:0]  row_raddr,
    input  logic [trpe_pkg::PIX_W-1:0]       row_rdata,
    output logic                             info_we,
    output logic [trpe_pkg::COL_W-1:0]       info_waddr,
    output trpe_pkg::trpe_info_t             info_wdata,
    output logic [trpe_pkg::COL_W-1:0]       info_raddr,
    input  trpe_pkg::trpe_info_t             info_rdata,
    output logic                             slot_we,
    output logic [trpe_pkg::COL_W-1:0]       slot_waddr,
    output logic [trpe_pkg::OFFSET_BITS-1:0] slot_wdata,
    output logic [trpe_pkg::COL_W-1:0]       slot_raddr,
    input  logic [trpe_pkg::OFFSET_BITS-1:0] slot_rdata,
    output trpe_pkg::trpe_emit_t             emit,
    input  logic                             emit_ready
);
    import trpe_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_OP0, S_OP1, S_FIN, S_VINFO, S_SCAN, S_SCMP, S_SEND,
        S_TAIL, S_CAP, S_CAPEM, S_CLOSE, S_SD0, S_SD1, S_SD2, S_SD3, S_SD4,
        S_EF, S_EFCMP, S_START, S_START2, S_DELTA, S_FLUSH
    } state_t;

    state_t                  state_reg, state_next;
    logic [COL_W-1:0]        clr_reg, clr_next;
    logic [1:0]              op_reg, op_next;
    logic                    sel_reg, sel_next;
    logic                    have_reg, have_next;
    logic [OFFSET_BITS-1:0]  wp_reg, wp_next;
    logic [COL_W-1:0]        cc_reg, cc_next;
    logic [LEN_W-1:0]        nv_reg, nv_next;
    logic [1:0]              visits_reg, visits_next;
    logic                    done_reg, done_next;
    logic                    hn_reg, hn_next;
    logic [COL_W-1:0]        x_reg, x_next;
    logic [LEN_W-1:0]        i_reg, i_next;
    logic [LEN_W-1:0]        lim_reg, lim_next;
    logic [RLEN_W-1:0]       rlen_reg, rlen_next;
    logic [PIX_W-1:0]        rcol_reg, rcol_next;
    logic [PIX_W-1:0]        c_reg, c_next;
    logic [PIX_W-1:0]        delta_reg, delta_next;
    logic                    m1_reg, m1_next;
    logic [D_W-1:0]          d_reg, d_next;
    logic [PIX_W-1:0]        mask_reg;
    logic [CFG_DATA_W-1:0]   rowlen_reg;
    logic [ROW_ADDR_W-1:0]   raddr_reg, raddr_next;
    logic [COL_W-1:0]        iaddr_reg, iaddr_next;
    logic [COL_W-1:0]        saddr_reg, saddr_next;

    logic [LEN_W-1:0]        len_eff;
    logic [SUM_W-1:0]        rl_wide;
    logic [LEN_W-1:0]        x_ext, x_plus1, cc_ext, cc_plus1, i_m1;
    logic [COL_W-1:0]        xr;
    logic [SUM_W-1:0]        lim_sum;
    logic [LEN_W-1:0]        lim_val;
    logic [PIX_W-1:0]        pix_m;
    logic [RLEN_W-1:0]       newlen;
    logic                    in_accept;
    state_t                  ret_state;
    logic [COL_W-1:0]        cc_adv;

    assign rl_wide   = SUM_W'(rowlen_reg);
    assign len_eff   = (rowlen_reg == '0) ? LEN_W'(1) :
                       (rl_wide > SUM_W'(ROW_MAX)) ? LEN_W'(ROW_MAX) : LEN_W'(rowlen_reg);
    assign x_ext     = LEN_W'(x_reg);
    assign x_plus1   = x_ext + LEN_W'(1);
    assign xr        = (x_plus1 < len_eff) ? (x_reg + COL_W'(1)) : x_reg;
    assign cc_ext    = LEN_W'(cc_reg);
    assign cc_plus1  = cc_ext + LEN_W'(1);
    assign cc_adv    = (cc_plus1 >= LEN_W'(ROW_MAX)) ? '0 : cc_reg + COL_W'(1);
    assign i_m1      = i_reg - LEN_W'(1);
    assign lim_sum   = SUM_W'(x_reg) + SUM_W'(info_rdata.len) + SUM_W'(2);
    assign lim_val   = (lim_sum > SUM_W'(len_eff)) ? len_eff : lim_sum[LEN_W-1:0];
    assign pix_m     = row_rdata & mask_reg;
    assign newlen    = rlen_reg + RLEN_W'(1);
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign ret_state = (op_reg == OP_PIXEL) ? S_OP0 : S_FLUSH;

    // The memories register the read, so the next-state address goes out directly
    assign row_raddr  = raddr_next;
    assign info_raddr = iaddr_next;
    assign slot_raddr = saddr_next;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        op_next     = op_reg;
        sel_next    = sel_reg;
        have_next   = have_reg;
        wp_next     = wp_reg;
        cc_next     = cc_reg;
        nv_next     = nv_reg;
        visits_next = visits_reg;
        done_next   = done_reg;
        hn_next     = hn_reg;
        x_next      = x_reg;
        i_next      = i_reg;
        lim_next    = lim_reg;
        rlen_next   = rlen_reg;
        rcol_next   = rcol_reg;
        c_next      = c_reg;
        delta_next  = delta_reg;
        m1_next     = m1_reg;
        d_next      = d_reg;
        row_we      = 1'b0;
        row_waddr   = {~sel_reg, cc_reg};
        row_wdata   = pixel_value;
        info_we     = 1'b0;
        info_waddr  = x_reg;
        info_wdata  = '0;
        slot_we     = 1'b0;
        slot_waddr  = x_reg;
        slot_wdata  = wp_reg + OFFSET_BITS'(1);
        emit        = '0;
        emit.offset = wp_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                info_we    = 1'b1;
                info_waddr = clr_reg;
                if (clr_reg == COL_W'(ROW_MAX - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + COL_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next = operation;
                    unique case (operation)
                        OP_PIXEL:
                        begin
                            row_we      = 1'b1;
                            done_next   = (cc_plus1 >= len_eff);
                            visits_next = '0;
                            state_next  = S_OP0;
                        end
                        OP_STEP:  state_next = S_OP1;
                        OP_FINAL: state_next = S_FIN;
                        default:  state_next = S_FLUSH;
                    endcase
                end
            end
            S_OP0:
            begin
                if (have_reg && visits_reg < 2'd2 && nv_reg < len_eff &&
                    (nv_reg < cc_ext || done_reg))
                begin
                    visits_next = visits_reg + 2'd1;
                    hn_next     = 1'b1;
                    x_next      = nv_reg[COL_W-1:0];
                    state_next  = S_VINFO;
                end
                else
                begin
                    if (done_reg)
                    begin
                        sel_next  = ~sel_reg;
                        have_next = 1'b1;
                        cc_next   = '0;
                        nv_next   = '0;
                    end
                    else
                    begin
                        cc_next = cc_reg + COL_W'(1);
                    end
                    state_next = S_FLUSH;
                end
            end
            S_OP1:
            begin
                if (have_reg && nv_reg < len_eff)
                begin
                    hn_next    = 1'b0;
                    x_next     = nv_reg[COL_W-1:0];
                    state_next = S_VINFO;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FIN:
            begin
                if (info_rdata.active)
                begin
                    emit.valid  = 1'b1;
                    emit.offset = slot_rdata;
                    emit.value  = PIX_W'(info_rdata.len);
                    if (emit_ready)
                    begin
                        info_we    = 1'b1;
                        info_waddr = cc_reg;
                        cc_next    = cc_adv;
                        state_next = S_FLUSH;
                    end
                end
                else
                begin
                    cc_next    = cc_adv;
                    state_next = S_FLUSH;
                end
            end
            S_VINFO:
            begin
                rlen_next = info_rdata.len;
                rcol_next = info_rdata.color;
                if (info_rdata.active)
                begin
                    lim_next   = lim_val;
                    i_next     = x_ext;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_SD0;
                end
            end
            S_SCAN:
            begin
                state_next = (i_reg < lim_reg) ? S_SCMP : S_SEND;
            end
            S_SCMP:
            begin
                if (pix_m == rcol_reg)
                begin
                    i_next     = i_reg + LEN_W'(1);
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                info_we = 1'b1;
                if (i_reg == lim_reg)
                begin
                    info_wdata.active = (newlen != REGION_LEN_MAX);
                    info_wdata.len    = newlen;
                    info_wdata.color  = rcol_reg;
                    rlen_next         = newlen;
                    state_next        = S_TAIL;
                end
                else
                begin
                    state_next = S_CLOSE;
                end
            end
            S_TAIL:
            begin
                if (info_rdata.active && x_ext < i_m1)
                begin
                    emit.valid  = 1'b1;
                    emit.offset = slot_rdata;
                    emit.value  = PIX_W'(info_rdata.len);
                    if (emit_ready)
                    begin
                        info_we    = 1'b1;
                        info_waddr = i_m1[COL_W-1:0];
                        state_next = S_CAP;
                    end
                end
                else
                begin
                    state_next = S_CAP;
                end
            end
            S_CAP:
            begin
                if (rlen_reg == REGION_LEN_MAX)
                begin
                    state_next = S_CAPEM;
                end
                else
                begin
                    nv_next    = i_reg;
                    state_next = ret_state;
                end
            end
            S_CAPEM:
            begin
                emit.valid  = 1'b1;
                emit.offset = slot_rdata;
                emit.value  = PIX_W'(REGION_LEN_MAX);
                if (emit_ready)
                begin
                    nv_next    = i_reg;
                    state_next = ret_state;
                end
            end
            S_CLOSE:
            begin
                emit.valid  = 1'b1;
                emit.offset = slot_rdata;
                emit.value  = PIX_W'(rlen_reg);
                if (emit_ready)
                begin
                    state_next = S_SD0;
                end
            end
            S_SD0:
            begin
                state_next = S_SD1;
            end
            S_SD1:
            begin
                c_next     = pix_m;
                state_next = S_SD2;
            end
            S_SD2:
            begin
                delta_next = c_reg - ((x_reg == '0) ? '0 : pix_m);
                state_next = hn_reg ? S_SD3 : S_DELTA;
            end
            S_SD3:
            begin
                m1_next    = (pix_m == c_reg);
                state_next = S_SD4;
            end
            S_SD4:
            begin
                if (m1_reg && pix_m == c_reg)
                begin
                    d_next     = D_W'(1);
                    state_next = S_EF;
                end
                else
                begin
                    state_next = S_DELTA;
                end
            end
            S_EF:
            begin
                if (SUM_W'(d_reg) <= SUM_W'(x_reg) && d_reg <= D_W'(REGION_LEN_MAX))
                begin
                    state_next = S_EFCMP;
                end
                else
                begin
                    state_next = S_START;
                end
            end
            S_EFCMP:
            begin
                if (info_rdata.active && info_rdata.len == RLEN_W'(d_reg - D_W'(1)) &&
                    info_rdata.color == c_reg)
                begin
                    state_next = S_DELTA;
                end
                else
                begin
                    d_next     = d_reg + D_W'(1);
                    state_next = S_EF;
                end
            end
            S_START:
            begin
                emit.valid = 1'b1;
                emit.value = delta_reg | ODD_BIT;
                if (emit_ready)
                begin
                    info_we           = 1'b1;
                    info_wdata.active = 1'b1;
                    info_wdata.color  = c_reg;
                    slot_we           = 1'b1;
                    wp_next           = wp_reg + OFFSET_BITS'(1);
                    state_next        = S_START2;
                end
            end
            S_START2:
            begin
                emit.valid = 1'b1;
                emit.value = '0;
                if (emit_ready)
                begin
                    wp_next    = wp_reg + OFFSET_BITS'(1);
                    nv_next    = x_plus1;
                    state_next = ret_state;
                end
            end
            S_DELTA:
            begin
                emit.valid = 1'b1;
                emit.value = delta_reg;
                if (emit_ready)
                begin
                    wp_next    = wp_reg + OFFSET_BITS'(1);
                    nv_next    = x_plus1;
                    state_next = ret_state;
                end
            end
            S_FLUSH:
            begin
                emit.flush = 1'b1;
                if (emit_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Read addresses follow the state so data lands in the consuming state
    always_comb
    begin
        raddr_next = raddr_reg;
        iaddr_next = iaddr_reg;
        saddr_next = saddr_reg;
        priority case (1'b1)
            (state_reg == S_IDLE):
            begin
                iaddr_next = cc_reg;
                saddr_next = cc_reg;
            end
            (state_next == S_VINFO):
            begin
                iaddr_next = x_next;
            end
            (state_reg == S_SCAN && state_next == S_SCMP):
            begin
                raddr_next = {sel_reg, i_reg[COL_W-1:0]};
            end
            (state_reg == S_SEND):
            begin
                iaddr_next = (state_next == S_TAIL) ? i_m1[COL_W-1:0] : iaddr_reg;
                saddr_next = (state_next == S_TAIL) ? i_m1[COL_W-1:0] : x_reg;
            end
            (state_next == S_CAPEM && state_reg == S_CAP):
            begin
                saddr_next = x_reg;
            end
            (state_reg == S_SD0):
            begin
                raddr_next = {sel_reg, x_reg};
            end
            (state_reg == S_SD1):
            begin
                raddr_next = {sel_reg, x_reg - COL_W'(1)};
            end
            (state_reg == S_SD2):
            begin
                raddr_next = {~sel_reg, x_reg};
            end
            (state_reg == S_SD3):
            begin
                raddr_next = {~sel_reg, xr};
            end
            (state_next == S_EFCMP):
            begin
                iaddr_next = x_reg - COL_W'(d_reg);
            end
            default:
            begin
                raddr_next = raddr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            op_reg     <= OP_PIXEL;
            sel_reg    <= 1'b0;
            have_reg   <= 1'b0;
            wp_reg     <= '0;
            cc_reg     <= '0;
            nv_reg     <= '0;
            visits_reg <= '0;
            done_reg   <= 1'b0;
            hn_reg     <= 1'b0;
            mask_reg   <= COLOR_MASK_RESET;
            rowlen_reg <= ROW_LEN_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            op_reg     <= op_next;
            sel_reg    <= sel_next;
            have_reg   <= have_next;
            wp_reg     <= wp_next;
            cc_reg     <= cc_next;
            nv_reg     <= nv_next;
            visits_reg <= visits_next;
            done_reg   <= done_next;
            hn_reg     <= hn_next;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_COLOR_MASK)
                begin
                    mask_reg <= cfg_data[PIX_W-1:0] & COLOR_MASK_FIX;
                end
                else if (cfg_index == CFG_ROW_LENGTH)
                begin
                    rowlen_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        i_reg     <= i_next;
        lim_reg   <= lim_next;
        rlen_reg  <= rlen_next;
        rcol_reg  <= rcol_next;
        c_reg     <= c_next;
        delta_reg <= delta_next;
        m1_reg    <= m1_next;
        d_reg     <= d_next;
        raddr_reg <= raddr_next;
        iaddr_reg <= iaddr_next;
        saddr_reg <= saddr_next;
    end

    a_no_emit_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !(emit.valid || emit.flush))
        else $error("byte write issued during clearing pass");

    a_emit_or_flush: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> !emit.flush)
        else $error("write and end of transaction requested together");

endmodule

>>> hdl/triangle_region_plane_encoder_core.sv
// Top level of the triangle region plane encoder core.
// After reset the block clears its region table, all ROW_MAX (1024) entries, and
// stalls its input meanwhile; configuration writes are taken at any time. It then
// takes one input transaction at a time and stalls until every byte write that
// transaction causes has been handed on. A next-row pixel makes up to two column
// visits; a column step makes at most one visit, and a finalize makes none. A
// visit scans the columns of an active region there (at most 128 columns); for a
// pixel it may make an edge check (at most 127 columns to the left). It writes its
// bytes as the output takes them; the row and region memories have one read port.
// The output register and a one-deep hold stage let the block carry on while a
// finished write waits to be taken; last marks the final write of a transaction.
module triangle_region_plane_encoder_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      operation,
    input  logic [trpe_pkg::PIX_W-1:0]      pixel_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [trpe_pkg::OUT_OFF_W-1:0]  byte_offset,
    output logic [trpe_pkg::PIX_W-1:0]      byte_value,
    output logic                            last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [trpe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trpe_pkg::CFG_DATA_W-1:0] cfg_data
);
    import trpe_pkg::*;

    logic                   row_we;
    logic [ROW_ADDR_W-1:0]  row_waddr, row_raddr;
    logic [PIX_W-1:0]       row_wdata, row_rdata;
    logic                   info_we;
    logic [COL_W-1:0]       info_waddr, info_raddr;
    trpe_info_t             info_wdata, info_rdata;
    logic [INFO_W-1:0]      info_rbits;
    logic                   slot_we;
    logic [COL_W-1:0]       slot_waddr, slot_raddr;
    logic [OFFSET_BITS-1:0] slot_wdata, slot_rdata;
    trpe_emit_t             emit;
    logic                   emit_ready;

    // Configuration is always accepted
    assign cfg_ready  = 1'b1;
    assign info_rdata = trpe_info_t'(info_rbits);

    // Both row buffers share one memory; the select bit picks the half
    trpe_ram #(.WIDTH(PIX_W), .DEPTH(2 * ROW_MAX)) u_row_ram (
        .clk     (clk),
        .wr_en   (row_we),
        .wr_addr (row_waddr),
        .wr_data (row_wdata),
        .rd_addr (row_raddr),
        .rd_data (row_rdata)
    );

    // Region active flag, length and colour per column
    trpe_ram #(.WIDTH(INFO_W), .DEPTH(ROW_MAX)) u_info_ram (
        .clk     (clk),
        .wr_en   (info_we),
        .wr_addr (info_waddr),
        .wr_data (info_wdata),
        .rd_addr (info_raddr),
        .rd_data (info_rbits)
    );

    // Stream position of each region's length byte
    trpe_ram #(.WIDTH(OFFSET_BITS), .DEPTH(ROW_MAX)) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_we),
        .wr_addr (slot_waddr),
        .wr_data (slot_wdata),
        .rd_addr (slot_raddr),
        .rd_data (slot_rdata)
    );

    trpe_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .pixel_value (pixel_value),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .row_we      (row_we),
        .row_waddr   (row_waddr),
        .row_wdata   (row_wdata),
        .row_raddr   (row_raddr),
        .row_rdata   (row_rdata),
        .info_we     (info_we),
        .info_waddr  (info_waddr),
        .info_wdata  (info_wdata),
        .info_raddr  (info_raddr),
        .info_rdata  (info_rdata),
        .slot_we     (slot_we),
        .slot_waddr  (slot_waddr),
        .slot_wdata  (slot_wdata),
        .slot_raddr  (slot_raddr),
        .slot_rdata  (slot_rdata),
        .emit        (emit),
        .emit_ready  (emit_ready)
    );

    trpe_obuf u_obuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .emit        (emit),
        .emit_ready  (emit_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .byte_offset (byte_offset),
        .byte_value  (byte_value),
        .last        (last)
    );

endmodule
